FILE: rtl/rne_pkg.sv
package rne_pkg;

  localparam int VAL_W = 12;
  localparam int SYM_W = 8;
  localparam int DIG_W = 4;
  localparam int CNT_W = 2;
  localparam int THR_W = 14;
  localparam int SCL_W = 10;

  localparam logic [VAL_W-1:0] MAX_VALID = 12'd3999;

  // ASCII letters of the numeral
  localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;
  localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
  localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
  localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
  localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
  localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
  localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
  localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;

  // microprogram steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_REP,
    ST_ONE_FIVE,
    ST_FIVE_END,
    ST_FIVE_REP,
    ST_ONE_TEN,
    ST_TEN_END,
    ST_ERR
  } step_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ONE,
    EM_FIVE,
    EM_TEN,
    EM_ERR
  } emit_t;

  // next-address selection
  typedef enum logic [2:0] {
    JC_START,
    JC_ALWAYS,
    JC_DISPATCH,
    JC_CNTNZ,
    JC_FIN
  } jcond_t;

  typedef enum logic [1:0] {
    DEC_TH,
    DEC_HU,
    DEC_TE,
    DEC_UN
  } decade_t;

  typedef struct packed {
    emit_t  emit;
    logic   split;
    logic   cnt_dec;
    jcond_t jc;
    step_t  target;
  } ctrl_t;

  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic             cnt_zero;
    logic             rem_zero;
    logic             out_free;
    logic             in_err;
  } stat_t;

  typedef struct packed {
    logic go;
    logic accept;
  } seq_t;

  function automatic logic [SCL_W-1:0] scale(decade_t d);
    logic [SCL_W-1:0] s;
    case (d)
      DEC_TH:  s = 10'd1000;
      DEC_HU:  s = 10'd100;
      DEC_TE:  s = 10'd10;
      default: s = 10'd1;
    endcase
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] letter(decade_t d, emit_t e);
    logic [SYM_W-1:0] one;
    logic [SYM_W-1:0] five;
    logic [SYM_W-1:0] ten;
    logic [SYM_W-1:0] sym;
    case (d)
      DEC_TH: begin
        one = SYM_M; five = SYM_M; ten = SYM_M;
      end
      DEC_HU: begin
        one = SYM_C; five = SYM_D; ten = SYM_M;
      end
      DEC_TE: begin
        one = SYM_X; five = SYM_L; ten = SYM_C;
      end
      default: begin
        one = SYM_I; five = SYM_V; ten = SYM_X;
      end
    endcase
    case (e)
      EM_ONE:  sym = one;
      EM_FIVE: sym = five;
      EM_TEN:  sym = ten;
      default: sym = SYM_NONE;
    endcase
    return sym;
  endfunction

  // entry step of the letter routine for one digit
  function automatic step_t dispatch(logic [DIG_W-1:0] digit);
    step_t s;
    case (digit) inside
      4'd0:         s = ST_SPLIT;
      [4'd1:4'd3]:  s = ST_REP;
      4'd4:         s = ST_ONE_FIVE;
      [4'd5:4'd8]:  s = ST_FIVE_REP;
      4'd9:         s = ST_ONE_TEN;
      default:      s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/rne_ucode_rom.sv
module rne_ucode_rom (
  input  rne_pkg::step_t step,
  output rne_pkg::ctrl_t ctrl
);

  // control word per step
  always_comb begin
    ctrl = '{emit: rne_pkg::EM_NONE, split: 1'b0, cnt_dec: 1'b0,
             jc: rne_pkg::JC_ALWAYS, target: rne_pkg::ST_IDLE};
    case (step)
      rne_pkg::ST_IDLE: begin
        ctrl.jc = rne_pkg::JC_START;
      end
      rne_pkg::ST_SPLIT: begin
        ctrl.split = 1'b1;
        ctrl.jc    = rne_pkg::JC_DISPATCH;
      end
      rne_pkg::ST_REP: begin
        ctrl.emit    = rne_pkg::EM_ONE;
        ctrl.cnt_dec = 1'b1;
        ctrl.jc      = rne_pkg::JC_CNTNZ;
        ctrl.target  = rne_pkg::ST_REP;
      end
      rne_pkg::ST_ONE_FIVE: begin
        ctrl.emit   = rne_pkg::EM_ONE;
        ctrl.target = rne_pkg::ST_FIVE_END;
      end
      rne_pkg::ST_FIVE_END: begin
        ctrl.emit = rne_pkg::EM_FIVE;
        ctrl.jc   = rne_pkg::JC_FIN;
      end
      rne_pkg::ST_FIVE_REP: begin
        ctrl.emit    = rne_pkg::EM_FIVE;
        ctrl.cnt_dec = 1'b1;
        ctrl.jc      = rne_pkg::JC_CNTNZ;
        ctrl.target  = rne_pkg::ST_REP;
      end
      rne_pkg::ST_ONE_TEN: begin
        ctrl.emit   = rne_pkg::EM_ONE;
        ctrl.target = rne_pkg::ST_TEN_END;
      end
      rne_pkg::ST_TEN_END: begin
        ctrl.emit = rne_pkg::EM_TEN;
        ctrl.jc   = rne_pkg::JC_FIN;
      end
      rne_pkg::ST_ERR: begin
        ctrl.emit = rne_pkg::EM_ERR;
      end
      default: begin
        ctrl.target = rne_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rne_sequencer.sv
module rne_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rne_pkg::ctrl_t ctrl,
  input  rne_pkg::stat_t stat,
  output rne_pkg::step_t step,
  output rne_pkg::seq_t  seq
);

  rne_pkg::step_t upc_r;
  rne_pkg::step_t upc_nxt;
  rne_pkg::step_t finish_tgt;
  logic           go;

  // a step advances once its letter has room and, when idle, an item is offered
  always_comb begin
    go = ((ctrl.emit == rne_pkg::EM_NONE) || stat.out_free) &&
         ((ctrl.jc != rne_pkg::JC_START) || in_valid);
    seq.go     = go;
    seq.accept = (ctrl.jc == rne_pkg::JC_START) && in_valid;
    step       = upc_r;
  end

  // next step address
  always_comb begin
    finish_tgt = stat.rem_zero ? rne_pkg::ST_IDLE : rne_pkg::ST_SPLIT;
    upc_nxt    = upc_r;
    if (go) begin
      case (ctrl.jc)
        rne_pkg::JC_START:    upc_nxt = stat.in_err ? rne_pkg::ST_ERR : rne_pkg::ST_SPLIT;
        rne_pkg::JC_ALWAYS:   upc_nxt = ctrl.target;
        rne_pkg::JC_DISPATCH: upc_nxt = rne_pkg::dispatch(stat.digit);
        rne_pkg::JC_CNTNZ:    upc_nxt = stat.cnt_zero ? finish_tgt : ctrl.target;
        rne_pkg::JC_FIN:      upc_nxt = finish_tgt;
        default:              upc_nxt = rne_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= rne_pkg::ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: rtl/rne_datapath.sv
module rne_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rne_pkg::VAL_W-1:0]  in_value,
  input  rne_pkg::ctrl_t             ctrl,
  input  rne_pkg::seq_t              seq,
  input  logic                       out_ready,
  output rne_pkg::stat_t             stat,
  output logic                       out_valid,
  output logic [rne_pkg::SYM_W-1:0]  out_symbol,
  output logic                       out_last,
  output logic                       out_error
);

  logic [rne_pkg::VAL_W-1:0] rem_r;
  logic [rne_pkg::VAL_W-1:0] rem_nxt;
  rne_pkg::decade_t          dec_r;
  rne_pkg::decade_t          dec_nxt;
  rne_pkg::decade_t          cur_r;
  rne_pkg::decade_t          cur_nxt;
  logic [rne_pkg::CNT_W-1:0] cnt_r;
  logic [rne_pkg::CNT_W-1:0] cnt_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [rne_pkg::SYM_W-1:0] sym_r;
  logic [rne_pkg::SYM_W-1:0] sym_nxt;
  logic                      last_r;
  logic                      last_nxt;
  logic                      err_r;
  logic                      err_nxt;

  logic [rne_pkg::DIG_W-1:0] q;
  logic [rne_pkg::THR_W-1:0] sub;
  logic [rne_pkg::THR_W-1:0] thr;
  logic [rne_pkg::SCL_W-1:0] scale_w;
  logic                      fin;
  logic                      emit_go;

  // digit of the current decade: largest k up to 9 whose multiple of the scale is not above the remainder
  always_comb begin
    scale_w = rne_pkg::scale(dec_r);
    q       = '0;
    sub     = '0;
    thr     = '0;
    for (int k = 1; k <= 9; k++) begin
      thr = rne_pkg::THR_W'(k) * {{(rne_pkg::THR_W - rne_pkg::SCL_W){1'b0}}, scale_w};
      if ({{(rne_pkg::THR_W - rne_pkg::VAL_W){1'b0}}, rem_r} >= thr) begin
        q   = rne_pkg::DIG_W'(k);
        sub = thr;
      end
    end
  end

  // status toward the sequencer
  always_comb begin
    stat.digit    = q;
    stat.cnt_zero = (cnt_r == '0);
    stat.rem_zero = (rem_r == '0);
    stat.out_free = !out_valid_r || out_ready;
    stat.in_err   = (in_value == '0) || (in_value > rne_pkg::MAX_VALID);
  end

  // remainder, decade and repeat count
  always_comb begin
    rem_nxt = rem_r;
    dec_nxt = dec_r;
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    if (seq.accept) begin
      rem_nxt = in_value;
      dec_nxt = rne_pkg::DEC_TH;
    end else if (seq.go && ctrl.split) begin
      rem_nxt = rem_r - sub[rne_pkg::VAL_W-1:0];
      dec_nxt = rne_pkg::decade_t'(dec_r + 2'd1);
      cur_nxt = dec_r;
      cnt_nxt = (q >= 4'd5) ? rne_pkg::CNT_W'(q - 4'd5) : rne_pkg::CNT_W'(q - 4'd1);
    end else if (seq.go && ctrl.cnt_dec) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // output register: load a letter on an emitting step, drop it on transfer
  always_comb begin
    fin     = (ctrl.jc == rne_pkg::JC_FIN) ||
              ((ctrl.jc == rne_pkg::JC_CNTNZ) && (cnt_r == '0));
    emit_go = seq.go && (ctrl.emit != rne_pkg::EM_NONE);
    out_valid_nxt = out_valid_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      sym_nxt       = rne_pkg::letter(cur_r, ctrl.emit);
      err_nxt       = (ctrl.emit == rne_pkg::EM_ERR);
      last_nxt      = (ctrl.emit == rne_pkg::EM_ERR) || (fin && (rem_r == '0));
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dec_r  <= dec_nxt;
    cur_r  <= cur_nxt;
    cnt_r  <= cnt_nxt;
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = sym_r;
  assign out_last   = last_r;
  assign out_error  = err_r;

endmodule

FILE: rtl/roman_numeral_encoder.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_ready  in_value[11:0]
// out_      output     out_valid/out_ready  out_symbol[7:0], out_last, out_error
//
// The waiting step takes the value, then each decade from the thousands down costs one
// split step plus one step per letter; decades below the last letter are skipped. An
// error value takes a single error step that emits one letter flagged last and error.
// The step counter of the microprogram holds on an emitting step while the output
// register is full and not taken. Reset is synchronous: it returns the step counter to
// idle and empties the output register.
module roman_numeral_encoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rne_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rne_pkg::SYM_W-1:0] out_symbol,
  output logic                      out_last,
  output logic                      out_error
);

  rne_pkg::step_t step;
  rne_pkg::ctrl_t ctrl;
  rne_pkg::stat_t stat;
  rne_pkg::seq_t  seq;

  rne_ucode_rom u_rom (
    .step (step),
    .ctrl (ctrl)
  );

  rne_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .ctrl     (ctrl),
    .stat     (stat),
    .step     (step),
    .seq      (seq)
  );

  rne_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_value),
    .ctrl       (ctrl),
    .seq        (seq),
    .out_ready  (out_ready),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .out_error  (out_error)
  );

  // take an item only on the waiting step of the program
  assign in_ready = (ctrl.jc == rne_pkg::JC_START);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

import rne_pkg::*;

// One expected letter of a numeral
typedef struct packed {
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic             error;
} numeral_letter_t;

class numeral_scoreboard;
  numeral_letter_t letters_due[$];
  int              mismatches = 0;

  // Count every mismatch; keep the log short
  task report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  function void push_letter(logic [SYM_W-1:0] sym);
    numeral_letter_t l;
    l.symbol = sym;
    l.last   = 1'b0;
    l.error  = 1'b0;
    letters_due.push_back(l);
  endfunction

  // Append the letters of one decade digit
  function void push_digit(int unsigned digit, logic [SYM_W-1:0] one,
                           logic [SYM_W-1:0] five, logic [SYM_W-1:0] ten);
    int unsigned r;
    if (digit == 9) begin
      push_letter(one);
      push_letter(ten);
    end else if (digit == 4) begin
      push_letter(one);
      push_letter(five);
    end else begin
      r = digit;
      if (r >= 5) begin
        push_letter(five);
        r -= 5;
      end
      while (r != 0) begin
        push_letter(one);
        r--;
      end
    end
  endfunction

  // Expand an accepted value into the letters it must produce
  function void note_value(logic [VAL_W-1:0] value);
    int unsigned     v;
    numeral_letter_t l;
    v = value;
    if (v == 0 || v > MAX_VALID) begin
      l.symbol = SYM_NONE;
      l.last   = 1'b1;
      l.error  = 1'b1;
      letters_due.push_back(l);
      return;
    end
    for (int unsigned k = 0; k < v / 1000; k++) push_letter(SYM_M);
    push_digit((v / 100) % 10, SYM_C, SYM_D, SYM_M);
    push_digit((v / 10) % 10, SYM_X, SYM_L, SYM_C);
    push_digit(v % 10, SYM_I, SYM_V, SYM_X);
    letters_due[$].last = 1'b1;
  endfunction

  // Compare one output transfer with the oldest expected letter
  task check_letter(logic [SYM_W-1:0] sym, logic last_flag, logic err_flag);
    numeral_letter_t want;
    if (letters_due.size() == 0) begin
      report($sformatf("unexpected letter %h last %b error %b", sym, last_flag, err_flag));
      return;
    end
    want = letters_due.pop_front();
    if (sym !== want.symbol)
      report($sformatf("symbol %h, expected %h", sym, want.symbol));
    if (last_flag !== want.last)
      report($sformatf("last %b, expected %b (symbol %h)", last_flag, want.last, want.symbol));
    if (err_flag !== want.error)
      report($sformatf("error %b, expected %b (symbol %h)", err_flag, want.error, want.symbol));
  endtask

  function int pending();
    return letters_due.size();
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT = 600000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [VAL_W-1:0] in_value  = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [SYM_W-1:0] out_symbol;
  logic             out_last;
  logic             out_error;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int unsigned       cycles        = 0;
  numeral_scoreboard sb            = new();

  roman_numeral_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_symbol(out_symbol),
    .out_last  (out_last),
    .out_error (out_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_value(in_value);
    if (rst_n && out_valid && out_ready) sb.check_letter(out_symbol, out_last, out_error);
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one value; entered and left at a falling edge
  task send_value(logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mostly valid values, with zero and out-of-range mixed in
  function logic [VAL_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 13) return VAL_W'($urandom_range(4095, 4000));
    if (r < 35) return VAL_W'($urandom_range(99, 1));
    return VAL_W'($urandom_range(3999, 1));
  endfunction

  task send_random(int count);
    for (int i = 0; i < count; i++) send_value(random_value());
  endtask

  initial begin
    logic [VAL_W-1:0] corner_values[$];
    corner_values = '{12'd0, 12'd4095, 12'd4000, 12'd3999, 12'd1, 12'd4, 12'd5,
                      12'd9, 12'd10, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1000,
                      12'd3888, 12'd1994, 12'd3000, 12'd444, 12'd999, 12'd3,
                      12'd8, 12'd49, 12'd4001, 12'd2048, 12'd2730};

    // Hold reset, then release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners, no idling
    foreach (corner_values[i]) send_value(corner_values[i]);

    // Random values under three idling patterns
    send_idle_pct = 20;
    recv_idle_pct = 88;
    send_random(100);
    send_idle_pct = 88;
    recv_idle_pct = 20;
    send_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(105);
    in_valid = 1'b0;

    // Drain outstanding letters, then let the block settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
